### hw/rtl/gwr_pkg.sv
// Shared types, codes and constants of the grid wavefront route unit.
`default_nettype none
package gwr_pkg;

    // Grid defaults and fixed field widths.
    localparam int GRID_X_DEF = 8;
    localparam int GRID_Y_DEF = 8;
    localparam int COORD_W = 3;
    localparam int EXT_W = 4;
    localparam int DIST_W = 6;

    // Configuration register indexes.
    localparam logic CFG_GRID_X = 1'b0;
    localparam logic CFG_GRID_Y = 1'b1;

    // Input opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ROUTE = 1'b1;

    // Route status codes.
    localparam logic [1:0] ST_MOVE = 2'd0;
    localparam logic [1:0] ST_AT_TARGET = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;
    localparam logic [1:0] ST_UNREACHABLE = 2'd3;

    // Move directions.
    localparam logic [1:0] DIR_UP = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Input transaction payload.
    typedef struct packed {
        logic opcode;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic cell_wall;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0] direction;
        logic [1:0] route_status;
        logic last_move;
    } out_item_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clear;
        logic step;
        logic [DIST_W-1:0] d;
        logic [DIST_W-1:0] pv;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [EXT_W-1:0] ex;
        logic [EXT_W-1:0] ey;
        logic wr_en;
        logic [COORD_W-1:0] wr_x;
        logic [COORD_W-1:0] wr_y;
        logic wr_wall;
    } cell_ctrl_t;

    // Status that each cell reports.
    typedef struct packed {
        logic wall;
        logic visited;
        logic front;
        logic grow;
        logic pred;
    } cell_stat_t;

endpackage
`default_nettype wire

### hw/rtl/gwr_cell.sv
// One grid cell: wall bit, visited flag and wave distance.
`default_nettype none
module gwr_cell #(
    parameter int CX = 0,
    parameter int CY = 0
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire gwr_pkg::cell_ctrl_t ctrl,
    input wire logic [3:0] nbr_front,
    output gwr_pkg::cell_stat_t stat
);

    localparam logic [gwr_pkg::COORD_W-1:0] MY_X = CX[gwr_pkg::COORD_W-1:0];
    localparam logic [gwr_pkg::COORD_W-1:0] MY_Y = CY[gwr_pkg::COORD_W-1:0];

    logic wall_reg;
    logic visited_reg;
    logic [gwr_pkg::DIST_W-1:0] dist_reg;
    logic in_ext;
    logic grow;

    // The cell takes part in a route only inside the active extent.
    assign in_ext = ({1'b0, MY_X} < ctrl.ex) && ({1'b0, MY_Y} < ctrl.ey);

    // An open, unvisited cell joins the wave when a neighbor is on the front.
    assign grow = ctrl.step && !visited_reg && !wall_reg && in_ext && (|nbr_front);

    assign stat.wall = wall_reg;
    assign stat.visited = visited_reg;
    assign stat.front = visited_reg && (dist_reg == ctrl.d);
    assign stat.grow = grow;
    assign stat.pred = visited_reg && (dist_reg == ctrl.pv);

    // Wall bit, written by write transactions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg <= 1'b0;
        end
        else if (ctrl.wr_en && ctrl.wr_x == MY_X && ctrl.wr_y == MY_Y)
        begin
            wall_reg <= ctrl.wr_wall;
        end
    end

    // Visited flag: seeded at the start cell, set as the wave arrives.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            visited_reg <= (ctrl.sx == MY_X) && (ctrl.sy == MY_Y);
        end
        else if (grow)
        begin
            visited_reg <= 1'b1;
        end
    end

    // Distance from the start cell.
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            dist_reg <= '0;
        end
        else if (grow)
        begin
            dist_reg <= ctrl.d + 1'b1;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/grid_wavefront_route_unit.sv
// Top level of the grid wavefront route unit: cell array and route sequencer.
//
// Usage: input transactions arrive on in_valid / in_stall with in_data. A write
// transaction sets one cell's wall bit and completes with no
// result. A route transaction yields one or more output transactions on
// out_valid / out_stall: the moves from start to target with last_move on the
// final one, or a single status transaction (at target, blocked, unreachable).
// The extent registers are written through cfg_we / cfg_index / cfg_data.
// Phases: the endpoint check, then wave expansion (the cell array advances the wave
// by one step per cycle), then backtracking one move at a time, then for each
// emitted move a store read and an output load.
// in_stall is high while a route is in progress. When the receiver stalls the
// output register holds its transaction and the sequencer waits.
// Reset clears all walls to open, sets both extents to 8 and empties the output.
`default_nettype none
module grid_wavefront_route_unit #(
    parameter int GRID_X = gwr_pkg::GRID_X_DEF,
    parameter int GRID_Y = gwr_pkg::GRID_Y_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_stall,
    input wire gwr_pkg::in_item_t in_data,
    output logic out_valid,
    input wire logic out_stall,
    output gwr_pkg::out_item_t out_data,
    input wire logic cfg_we,
    input wire logic cfg_index,
    input wire logic [gwr_pkg::EXT_W-1:0] cfg_data
);

    localparam int CELLS = GRID_X * GRID_Y;
    localparam int CELL_W = $clog2(CELLS);
    localparam int CW = gwr_pkg::COORD_W;
    localparam int DW = gwr_pkg::DIST_W;
    localparam int EW = gwr_pkg::EXT_W;
    localparam logic [EW-1:0] GX_E = EW'(GRID_X);
    localparam logic [EW-1:0] GY_E = EW'(GRID_Y);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WAVE = 3'd2;
    localparam logic [2:0] S_BACK = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_PUT = 3'd5;
    localparam logic [2:0] S_SINGLE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [EW-1:0] xext_reg, yext_reg;
    logic [EW-1:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [CW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [DW-1:0] d_reg, d_next;
    logic [DW-1:0] v_reg, v_next;
    logic [DW-1:0] slot_reg, slot_next;
    logic [DW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] k_reg, k_next;
    logic [1:0] status_reg, status_next;
    logic [1:0] rd_dir_reg;
    logic out_valid_reg, out_valid_next;
    gwr_pkg::out_item_t out_data_reg, out_data_next;
    logic [1:0] move_mem [CELLS];

    gwr_pkg::cell_ctrl_t ctrl;
    gwr_pkg::cell_stat_t stat [GRID_X][GRID_Y];
    logic [CELLS-1:0] wall_vec, visited_vec, grow_vec, pred_vec;

    logic in_acc, out_free;
    logic [EW-1:0] ex_eff, ey_eff;
    logic bad_end, same_end, tgt_visited, any_grow;
    logic [CELL_W-1:0] s_idx, t_idx;
    logic [3:0] cand;
    logic [CELL_W-1:0] n_idx [4];
    logic back_we;
    logic [1:0] back_dir;
    logic [DW-1:0] slot_dec;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // Effective extents: zero acts as one, large values saturate to the grid.
    assign ex_eff = (xext_reg == '0) ? EW'(1) : ((xext_reg > GX_E) ? GX_E : xext_reg);
    assign ey_eff = (yext_reg == '0) ? EW'(1) : ((yext_reg > GY_E) ? GY_E : yext_reg);

    // Extent registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xext_reg <= EW'(8);
            yext_reg <= EW'(8);
        end
        else if (cfg_we)
        begin
            if (cfg_index == gwr_pkg::CFG_GRID_X)
            begin
                xext_reg <= cfg_data;
            end
            else
            begin
                yext_reg <= cfg_data;
            end
        end
    end

    // Broadcast control to the cell array.
    always_comb
    begin
        ctrl.clear = (state_reg == S_CHECK) && !bad_end && !same_end;
        ctrl.step = (state_reg == S_WAVE) && !tgt_visited;
        ctrl.d = d_reg;
        ctrl.pv = v_reg - 1'b1;
        ctrl.sx = sx_reg;
        ctrl.sy = sy_reg;
        ctrl.ex = ex_reg;
        ctrl.ey = ey_reg;
        ctrl.wr_en = in_acc && (in_data.opcode == gwr_pkg::OP_WRITE);
        ctrl.wr_x = in_data.cell_x;
        ctrl.wr_y = in_data.cell_y;
        ctrl.wr_wall = in_data.cell_wall;
    end

    // Cell array; each cell sees the wave front of its four neighbors.
    for (genvar gx = 0; gx < GRID_X; gx++)
    begin : g_row
        for (genvar gy = 0; gy < GRID_Y; gy++)
        begin : g_col
            logic [3:0] nf;
            if (gx > 0)
            begin : g_xm
                assign nf[0] = stat[gx-1][gy].front;
            end
            else
            begin : g_xm0
                assign nf[0] = 1'b0;
            end
            if (gy > 0)
            begin : g_ym
                assign nf[1] = stat[gx][gy-1].front;
            end
            else
            begin : g_ym0
                assign nf[1] = 1'b0;
            end
            if (gy < GRID_Y - 1)
            begin : g_yp
                assign nf[2] = stat[gx][gy+1].front;
            end
            else
            begin : g_yp0
                assign nf[2] = 1'b0;
            end
            if (gx < GRID_X - 1)
            begin : g_xp
                assign nf[3] = stat[gx+1][gy].front;
            end
            else
            begin : g_xp0
                assign nf[3] = 1'b0;
            end

            gwr_cell #(
                .CX(gx),
                .CY(gy)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .ctrl(ctrl),
                .nbr_front(nf),
                .stat(stat[gx][gy])
            );

            assign wall_vec[gx*GRID_Y+gy] = stat[gx][gy].wall;
            assign visited_vec[gx*GRID_Y+gy] = stat[gx][gy].visited;
            assign grow_vec[gx*GRID_Y+gy] = stat[gx][gy].grow;
            assign pred_vec[gx*GRID_Y+gy] = stat[gx][gy].pred;
        end
    end

    // Endpoint checks and wave status.
    assign s_idx = CELL_W'(int'(sx_reg) * GRID_Y + int'(sy_reg));
    assign t_idx = CELL_W'(int'(tx_reg) * GRID_Y + int'(ty_reg));
    assign bad_end = ({1'b0, sx_reg} >= ex_reg) || ({1'b0, sy_reg} >= ey_reg)
        || ({1'b0, tx_reg} >= ex_reg) || ({1'b0, ty_reg} >= ey_reg)
        || wall_vec[s_idx] || wall_vec[t_idx];
    assign same_end = (sx_reg == tx_reg) && (sy_reg == ty_reg);
    assign tgt_visited = visited_vec[t_idx];
    assign any_grow = |grow_vec;

    // Backtrack candidates in the order -x, -y, +y, +x.
    always_comb
    begin
        n_idx[0] = CELL_W'((int'(cx_reg) - 1) * GRID_Y + int'(cy_reg));
        n_idx[1] = CELL_W'(int'(cx_reg) * GRID_Y + int'(cy_reg) - 1);
        n_idx[2] = CELL_W'(int'(cx_reg) * GRID_Y + int'(cy_reg) + 1);
        n_idx[3] = CELL_W'((int'(cx_reg) + 1) * GRID_Y + int'(cy_reg));
        cand[0] = (cx_reg != '0) && pred_vec[n_idx[0]];
        cand[1] = (cy_reg != '0) && pred_vec[n_idx[1]];
        cand[2] = ({1'b0, cy_reg} + 1'b1 < ey_reg) && pred_vec[n_idx[2]];
        cand[3] = ({1'b0, cx_reg} + 1'b1 < ex_reg) && pred_vec[n_idx[3]];
    end

    assign slot_dec = slot_reg - 1'b1;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ex_next = ex_reg;
        ey_next = ey_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        tx_next = tx_reg;
        ty_next = ty_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        d_next = d_reg;
        v_next = v_reg;
        slot_next = slot_reg;
        cnt_next = cnt_reg;
        k_next = k_reg;
        status_next = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        back_we = 1'b0;
        back_dir = gwr_pkg::DIR_UP;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_data.opcode == gwr_pkg::OP_ROUTE)
                begin
                    ex_next = ex_eff;
                    ey_next = ey_eff;
                    sx_next = in_data.start_x;
                    sy_next = in_data.start_y;
                    tx_next = in_data.target_x;
                    ty_next = in_data.target_y;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                d_next = '0;
                if (bad_end)
                begin
                    status_next = gwr_pkg::ST_BLOCKED;
                    state_next = S_SINGLE;
                end
                else if (same_end)
                begin
                    status_next = gwr_pkg::ST_AT_TARGET;
                    state_next = S_SINGLE;
                end
                else
                begin
                    state_next = S_WAVE;
                end
            end
            S_WAVE:
            begin
                if (tgt_visited)
                begin
                    cnt_next = d_reg;
                    slot_next = d_reg;
                    v_next = d_reg;
                    cx_next = tx_reg;
                    cy_next = ty_reg;
                    state_next = S_BACK;
                end
                else if (!any_grow)
                begin
                    status_next = gwr_pkg::ST_UNREACHABLE;
                    state_next = S_SINGLE;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                end
            end
            S_BACK:
            begin
                k_next = '0;
                if (slot_reg == '0 || cand == 4'b0000)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    back_we = 1'b1;
                    slot_next = slot_dec;
                    v_next = v_reg - 1'b1;
                    if (cand[0])
                    begin
                        back_dir = gwr_pkg::DIR_DOWN;
                        cx_next = cx_reg - 1'b1;
                    end
                    else if (cand[1])
                    begin
                        back_dir = gwr_pkg::DIR_RIGHT;
                        cy_next = cy_reg - 1'b1;
                    end
                    else if (cand[2])
                    begin
                        back_dir = gwr_pkg::DIR_LEFT;
                        cy_next = cy_reg + 1'b1;
                    end
                    else
                    begin
                        back_dir = gwr_pkg::DIR_UP;
                        cx_next = cx_reg + 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.direction = rd_dir_reg;
                    out_data_next.route_status = gwr_pkg::ST_MOVE;
                    out_data_next.last_move = (k_reg == cnt_reg - 1'b1);
                    if (k_reg == cnt_reg - 1'b1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.direction = gwr_pkg::DIR_UP;
                    out_data_next.route_status = status_reg;
                    out_data_next.last_move = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Route working registers and output payload.
    always_ff @(posedge clk)
    begin
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        tx_reg <= tx_next;
        ty_reg <= ty_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        d_reg <= d_next;
        v_reg <= v_next;
        slot_reg <= slot_next;
        cnt_reg <= cnt_next;
        k_reg <= k_next;
        status_reg <= status_next;
        out_data_reg <= out_data_next;
    end

    // Move store: written during backtracking, read in order when emitting.
    always_ff @(posedge clk)
    begin
        if (back_we)
        begin
            move_mem[slot_dec[CELL_W-1:0]] <= back_dir;
        end
        if (state_reg == S_READ)
        begin
            rd_dir_reg <= move_mem[k_reg[CELL_W-1:0]];
        end
    end

endmodule
`default_nettype wire

### test/grid_wavefront_route_unit_test.sv
// Testbench of the grid wavefront route unit: random maze routes checked against a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module grid_wavefront_route_unit_test;

    localparam int GX = gwr_pkg::GRID_X_DEF;
    localparam int GY = gwr_pkg::GRID_Y_DEF;
    localparam int CELL_COUNT = GX * GY;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int CW = gwr_pkg::COORD_W;
    localparam int EW = gwr_pkg::EXT_W;
    localparam int IN_W = $bits(gwr_pkg::in_item_t);

    int fail_count;
    int cycle_count;

    // Print one mismatch line and count it.
    task automatic report_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    // Scoreboard: holds its own copy of the wall map and extents and predicts routes.
    class route_scoreboard;
        bit walls [CELL_COUNT];
        logic [EW-1:0] x_reg;
        logic [EW-1:0] y_reg;
        gwr_pkg::out_item_t pending [$];

        function new();
            foreach (walls[i]) walls[i] = 1'b0;
            x_reg = 4'd8;
            y_reg = 4'd8;
        endfunction

        function void set_extent(logic idx, logic [EW-1:0] val);
            if (idx == gwr_pkg::CFG_GRID_X) x_reg = val;
            else y_reg = val;
        endfunction

        function int clamp_extent(logic [EW-1:0] r, int size);
            int e;
            e = r;
            if (e < 1) e = 1;
            if (e > size) e = size;
            return e;
        endfunction

        function void push_single(logic [1:0] st);
            gwr_pkg::out_item_t o;
            o.direction = gwr_pkg::DIR_UP;
            o.route_status = st;
            o.last_move = 1'b1;
            pending.push_back(o);
        endfunction

        // Note one accepted input transaction and queue the results it causes.
        function void note_input(gwr_pkg::in_item_t it);
            int ex, ey, sx, sy, tx, ty, d, cnt, slot, cx, cy, v, ni, nj, n;
            bit grew, found;
            bit seen [CELL_COUNT];
            int wave_dist [CELL_COUNT];
            logic [1:0] moves [CELL_COUNT];
            int dxs [4];
            int dys [4];
            logic [1:0] dirs [4];
            gwr_pkg::out_item_t o;
            dxs = '{-1, 0, 0, 1};
            dys = '{0, -1, 1, 0};
            dirs = '{gwr_pkg::DIR_DOWN, gwr_pkg::DIR_RIGHT, gwr_pkg::DIR_LEFT,
                     gwr_pkg::DIR_UP};
            if (it.opcode == gwr_pkg::OP_WRITE)
            begin
                walls[it.cell_x * GY + it.cell_y] = it.cell_wall;
                return;
            end
            ex = clamp_extent(x_reg, GX);
            ey = clamp_extent(y_reg, GY);
            sx = it.start_x; sy = it.start_y; tx = it.target_x; ty = it.target_y;
            if (sx >= ex || sy >= ey || tx >= ex || ty >= ey
                    || walls[sx * GY + sy] || walls[tx * GY + ty])
            begin
                push_single(gwr_pkg::ST_BLOCKED);
                return;
            end
            if (sx == tx && sy == ty)
            begin
                push_single(gwr_pkg::ST_AT_TARGET);
                return;
            end
            foreach (seen[i])
            begin
                seen[i] = 1'b0;
                wave_dist[i] = 0;
            end
            seen[sx * GY + sy] = 1'b1;
            d = 0;
            // Wave expansion, one front per pass.
            forever
            begin
                grew = 1'b0;
                for (int i = 0; i < ex; i++)
                    for (int j = 0; j < ey; j++)
                    begin
                        if (!seen[i * GY + j] || wave_dist[i * GY + j] != d) continue;
                        for (int k = 0; k < 4; k++)
                        begin
                            ni = i + dxs[k]; nj = j + dys[k];
                            if (ni < 0 || ni >= ex || nj < 0 || nj >= ey) continue;
                            n = ni * GY + nj;
                            if (walls[n] || seen[n]) continue;
                            seen[n] = 1'b1;
                            wave_dist[n] = (d + 1) & 127;
                            grew = 1'b1;
                        end
                    end
                d++;
                if (seen[tx * GY + ty]) break;
                if (!grew || d >= CELL_COUNT)
                begin
                    push_single(gwr_pkg::ST_UNREACHABLE);
                    return;
                end
            end
            // Backtrack from the target toward the start.
            cnt = wave_dist[tx * GY + ty];
            if (cnt > CELL_COUNT - 1) cnt = CELL_COUNT - 1;
            slot = cnt; cx = tx; cy = ty; v = cnt;
            while ((cx != sx || cy != sy) && slot > 0)
            begin
                found = 1'b0;
                for (int k = 0; k < 4 && !found; k++)
                begin
                    ni = cx + dxs[k]; nj = cy + dys[k];
                    if (ni < 0 || ni >= ex || nj < 0 || nj >= ey) continue;
                    n = ni * GY + nj;
                    if (!seen[n] || wave_dist[n] != v - 1) continue;
                    slot--;
                    moves[slot] = dirs[k];
                    cx = ni; cy = nj; v--;
                    found = 1'b1;
                end
                if (!found) break;
            end
            for (int k = 0; k < cnt; k++)
            begin
                o.direction = (k >= slot) ? moves[k] : gwr_pkg::DIR_UP;
                o.route_status = gwr_pkg::ST_MOVE;
                o.last_move = (k == cnt - 1);
                pending.push_back(o);
            end
        endfunction

        // Check one accepted result against the oldest expectation.
        task check_result(gwr_pkg::out_item_t got);
            gwr_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("result transaction with nothing expected");
                return;
            end
            want = pending.pop_front();
            if (got.direction !== want.direction)
                report_mismatch($sformatf("direction %0d, expected %0d",
                    got.direction, want.direction));
            if (got.route_status !== want.route_status)
                report_mismatch($sformatf("route_status %0d, expected %0d",
                    got.route_status, want.route_status));
            if (got.last_move !== want.last_move)
                report_mismatch($sformatf("last_move %0b, expected %0b",
                    got.last_move, want.last_move));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    gwr_pkg::in_item_t in_data;
    logic out_valid;
    logic out_stall;
    gwr_pkg::out_item_t out_data;
    logic cfg_we;
    logic cfg_index;
    logic [EW-1:0] cfg_data;

    route_scoreboard board;
    int hold_cycles;
    bit calm_output;
    bit calm_input;

    grid_wavefront_route_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter and timeout.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Result monitor: sample accepted result transactions at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    end

    // Receiver: random stalls, a calm stretch, and a long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else if (calm_output)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 30);
            end
        end
    end

    // Offer one transaction, with random idle gaps, until it is accepted.
    task automatic send_item(gwr_pkg::in_item_t it);
        if (!calm_input)
            while ($urandom_range(99) < 30)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall);
        board.note_input(it);
        @(negedge clk);
    endtask

    task automatic write_cell(int x, int y, bit w);
        gwr_pkg::in_item_t it;
        it = gwr_pkg::in_item_t'(IN_W'($urandom));
        it.opcode = gwr_pkg::OP_WRITE;
        it.cell_x = CW'(x); it.cell_y = CW'(y); it.cell_wall = w;
        send_item(it);
    endtask

    task automatic route(int sx, int sy, int tx, int ty);
        gwr_pkg::in_item_t it;
        it = gwr_pkg::in_item_t'(IN_W'($urandom));
        it.opcode = gwr_pkg::OP_ROUTE;
        it.start_x = CW'(sx); it.start_y = CW'(sy);
        it.target_x = CW'(tx); it.target_y = CW'(ty);
        send_item(it);
    endtask

    // Stop offering, wait for every expected result and let the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_extent(logic idx, logic [EW-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.set_extent(idx, val);
        @(negedge clk);
    endtask

    // Random item biased toward routes inside the current extent.
    task automatic random_item(int ex, int ey);
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            write_cell($urandom_range(7), $urandom_range(7), ($urandom_range(99) < 30));
        else if (pick < 90)
            route($urandom_range(ex - 1), $urandom_range(ey - 1),
                  $urandom_range(ex - 1), $urandom_range(ey - 1));
        else
            route($urandom_range(7), $urandom_range(7),
                  $urandom_range(7), $urandom_range(7));
    endtask

    initial
    begin
        logic [EW-1:0] xs [5];
        logic [EW-1:0] ys [5];
        board = new();
        fail_count = 0;
        hold_cycles = 0;
        calm_output = 1'b0;
        calm_input = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = gwr_pkg::CFG_GRID_X;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: corner to corner on an open grid, every direction, special cases.
        route(0, 0, 7, 7);
        route(7, 7, 0, 0);
        route(0, 7, 7, 0);
        route(3, 3, 3, 3);
        write_cell(2, 2, 1'b1);
        route(2, 2, 5, 5);
        route(5, 5, 2, 2);
        write_cell(0, 1, 1'b1);
        write_cell(1, 0, 1'b1);
        route(0, 0, 4, 4);
        route(4, 4, 0, 0);
        write_cell(0, 1, 1'b0);
        route(7, 0, 0, 7);
        write_cell(2, 2, 1'b0);
        write_cell(1, 0, 1'b0);
        drain();

        // Smallest extents: outside endpoints become blocked.
        write_extent(gwr_pkg::CFG_GRID_X, 4'd0);
        write_extent(gwr_pkg::CFG_GRID_Y, 4'd1);
        route(0, 0, 0, 0);
        route(0, 0, 1, 0);
        route(0, 0, 0, 1);
        drain();
        write_extent(gwr_pkg::CFG_GRID_X, 4'd15);
        write_extent(gwr_pkg::CFG_GRID_Y, 4'd2);
        route(0, 0, 7, 1);
        drain();

        // Long receiver hold-off while routes keep coming, to fill the block.
        write_extent(gwr_pkg::CFG_GRID_X, 4'd8);
        write_extent(gwr_pkg::CFG_GRID_Y, 4'd8);
        hold_cycles = 400;
        for (int i = 0; i < 6; i++) route(0, 0, 7, 7 - i);
        drain();

        // Random phases across several extents, one without idling.
        xs = '{4'd8, 4'd3, 4'd15, 4'd5, 4'd8};
        ys = '{4'd8, 4'd6, 4'd2, 4'd0, 4'd12};
        for (int p = 0; p < 5; p++)
        begin
            write_extent(gwr_pkg::CFG_GRID_X, xs[p]);
            write_extent(gwr_pkg::CFG_GRID_Y, ys[p]);
            calm_input = (p == 2);
            calm_output = (p == 2);
            for (int i = 0; i < 24; i++)
                random_item(board.clamp_extent(xs[p], GX), board.clamp_extent(ys[p], GY));
            drain();
        end

        if (fail_count == 0 && board.pending.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
